>>> hdl/mk_pkg.sv
// Shared types, constants, Morse tables and helpers of the Morse keyer.
`timescale 1ns / 1ps
package mk_pkg;

	// Time counter width and configuration register width
	localparam int TICK_W = 16;
	localparam int CFG_W  = 16;

	// Register indexes of the configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DOT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DASH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP  = 2'd2;

	localparam logic [CFG_W-1:0] DOT_RESET  = 16'd200;
	localparam logic [CFG_W-1:0] DASH_RESET = 16'd600;
	localparam logic [CFG_W-1:0] GAP_RESET  = 16'd100;

	// Input opcodes
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Character codes
	localparam logic [7:0] CHAR_A      = 8'h41;
	localparam logic [7:0] CHAR_Z      = 8'h5A;
	localparam logic [7:0] CHAR_LA     = 8'h61;
	localparam logic [7:0] CHAR_LZ     = 8'h7A;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	localparam int LETTER_COUNT = 26;
	localparam int LETTER_W     = 5;

	// Elements per letter, and element bits (bit 0 first, 1 = dash)
	localparam logic [2:0] MORSE_LEN [LETTER_COUNT] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
		3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
	};
	localparam logic [3:0] MORSE_BITS [LETTER_COUNT] = '{
		4'h2, 4'h1, 4'h5, 4'h1, 4'h0, 4'h4, 4'h3, 4'h0, 4'h0, 4'hE, 4'h5, 4'h2, 4'h3,
		4'h1, 4'h7, 4'h6, 4'hB, 4'h2, 4'h0, 4'h1, 4'h4, 4'h8, 4'h6, 4'h9, 4'hD, 4'h3
	};

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef enum logic [1:0] {
		K_TICK,
		K_LETTER,
		K_SPACE,
		K_OTHER
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [3:0] pattern;
		logic [2:0] count;
	} mk_cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ON,
		PH_GAP
	} phase_t;

	// Zero counts as one tick; a value too large for the counter saturates
	function automatic logic [TICK_W-1:0] load_count(input logic [CFG_W-1:0] r);
		logic [CFG_W-1:0] v;
		v = (r == '0) ? CFG_W'(1) : r;
		if ((v >> TICK_W) != '0)
			return '1;
		return TICK_W'(v);
	endfunction

endpackage

>>> hdl/mk_channels.sv
// Handshake channels of the Morse keyer: command input and result output.
`timescale 1ns / 1ps
interface mk_cmd_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] char_code;

	modport source (output valid, output opcode, output char_code, input ready);
	modport sink (input valid, input opcode, input char_code, output ready);
endinterface

interface mk_res_if;
	logic valid;
	logic ready;
	logic key_on;
	logic busy_res;
	logic dropped;

	modport source (output valid, output key_on, output busy_res, output dropped, input ready);
	modport sink (input valid, input key_on, input busy_res, input dropped, output ready);
endinterface

>>> hdl/mk_front.sv
// Front end: takes commands and classifies characters into Morse element codes.
`timescale 1ns / 1ps
module mk_front import mk_pkg::*; (
	mk_cmd_if.sink  cmd,
	input  logic    q_full,
	output logic    push,
	output mk_cmd_t push_data
);

	logic [7:0]          upper;
	logic [LETTER_W-1:0] letter;

	assign cmd.ready = !q_full;
	assign push      = cmd.valid && !q_full;

	always_comb begin
		upper  = (cmd.char_code >= CHAR_LA && cmd.char_code <= CHAR_LZ) ?
			cmd.char_code - CASE_OFFSET : cmd.char_code;
		letter = LETTER_W'(upper - CHAR_A);
		push_data.pattern = '0;
		push_data.count   = '0;
		if (cmd.opcode == OP_TICK) begin
			push_data.kind = K_TICK;
		end else if (upper >= CHAR_A && upper <= CHAR_Z) begin
			push_data.kind    = K_LETTER;
			push_data.pattern = MORSE_BITS[letter];
			push_data.count   = MORSE_LEN[letter];
		end else if (upper == CHAR_SPACE) begin
			push_data.kind = K_SPACE;
		end else begin
			push_data.kind = K_OTHER;
		end
	end

endmodule

>>> hdl/mk_queue.sv
// Short register queue between the front end and the sequencer.
`timescale 1ns / 1ps
module mk_queue import mk_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  mk_cmd_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    head_valid,
	output mk_cmd_t head
);

	mk_cmd_t           entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> hdl/mk_back.sv
// Sequencer: keying state, timing registers and the result register.
`timescale 1ns / 1ps
module mk_back import mk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  mk_cmd_t              head,
	output logic                 pop,
	mk_res_if.source             res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0]  dot_q, dash_q, gap_q;
	logic [3:0]        pat_q, pat_n;
	logic [2:0]        left_q, left_n;
	phase_t            phase_q, phase_n;
	logic [TICK_W-1:0] time_q, time_n;
	logic [1:0]        trail_q, trail_n;
	logic              drop_n;
	logic              key_n, busy_n;
	logic              res_valid_q, res_key_q, res_busy_q, res_drop_q;

	assign pop          = head_valid && (!res_valid_q || res.ready);
	assign res.valid    = res_valid_q;
	assign res.key_on   = res_key_q;
	assign res.busy_res = res_busy_q;
	assign res.dropped  = res_drop_q;

	// Next state
	always_comb begin
		logic [3:0]        el_pat;
		logic [2:0]        el_left;
		logic              start_el;
		logic              start_gap;
		logic [TICK_W-1:0] t_dec;
		pat_n     = pat_q;
		left_n    = left_q;
		phase_n   = phase_q;
		time_n    = time_q;
		trail_n   = trail_q;
		drop_n    = 1'b0;
		el_pat    = pat_q;
		el_left   = left_q;
		start_el  = 1'b0;
		start_gap = 1'b0;
		t_dec     = (time_q != '0) ? time_q - 1'b1 : time_q;
		case (head.kind)
			K_TICK: begin
				if (phase_q != PH_IDLE) begin
					time_n = t_dec;
					if (t_dec == '0) begin
						if (phase_q == PH_ON) begin
							start_gap = 1'b1;
						end else if (left_q != '0) begin
							start_el = 1'b1;
						end else if (trail_q != '0) begin
							trail_n   = trail_q - 1'b1;
							start_gap = 1'b1;
						end else begin
							phase_n = PH_IDLE;
							time_n  = '0;
							pat_n   = '0;
						end
					end
				end
			end
			K_LETTER: begin
				if (phase_q == PH_IDLE) begin
					el_pat   = head.pattern;
					el_left  = head.count;
					trail_n  = 2'd1;
					start_el = 1'b1;
				end else begin
					drop_n = 1'b1;
				end
			end
			K_SPACE: begin
				if (phase_q == PH_IDLE) begin
					pat_n     = '0;
					left_n    = '0;
					trail_n   = 2'd0;
					start_gap = 1'b1;
				end else begin
					drop_n = 1'b1;
				end
			end
			default: begin
				if (phase_q == PH_IDLE) begin
					pat_n     = '0;
					left_n    = '0;
					trail_n   = 2'd1;
					start_gap = 1'b1;
				end else begin
					drop_n = 1'b1;
				end
			end
		endcase
		if (start_el) begin
			pat_n   = el_pat >> 1;
			left_n  = el_left - 1'b1;
			phase_n = PH_ON;
			time_n  = load_count(el_pat[0] ? dash_q : dot_q);
		end
		if (start_gap) begin
			phase_n = PH_GAP;
			time_n  = load_count(gap_q);
		end
	end

	// Result fields
	always_comb begin
		key_n  = (phase_n == PH_ON);
		busy_n = (phase_n != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q  <= DOT_RESET;
			dash_q <= DASH_RESET;
			gap_q  <= GAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DOT:  dot_q  <= cfg_data;
				REG_DASH: dash_q <= cfg_data;
				REG_GAP:  gap_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q       <= '0;
			left_q      <= '0;
			phase_q     <= PH_IDLE;
			time_q      <= '0;
			trail_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pat_q   <= pat_n;
				left_q  <= left_n;
				phase_q <= phase_n;
				time_q  <= time_n;
				trail_q <= trail_n;
			end
			if (pop)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_key_q  <= key_n;
			res_busy_q <= busy_n;
			res_drop_q <= drop_n;
		end
	end

endmodule

>>> hdl/morse_keyer_unit.sv
// Top level of the Morse keyer: front end, command queue and sequencer.
//
//  channel  | dir | transfer carries                 | one per
//  ---------+-----+----------------------------------+--------------------------
//  cmd      | in  | opcode, char_code                | character or tick
//  res      | out | key_on, busy_res, dropped        | accepted command
//  cfg_*    | in  | cfg_index, cfg_data (write only) | register write
//
// One command per cycle sustained while res is not stalled; a command's result
// is registered once the sequencer pops it from the queue. The sequencer updates
// its state once per popped command, which sets that rate.
// A two-entry queue lets commands keep arriving while a result stalls on res.
// Reset clears the queue, the keying state and the result valid flag, and loads
// the timing registers with their defaults.
`timescale 1ns / 1ps
module morse_keyer_unit import mk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	mk_cmd_if.sink               cmd,
	mk_res_if.source             res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic    push, q_full, pop, head_valid;
	mk_cmd_t push_data, head;

	mk_front u_front (
		.cmd       (cmd),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	mk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	mk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

endmodule

>>> hdl/mk_checker.sv
// Port-level checks of the Morse keyer, bound to the top level.
`timescale 1ns / 1ps
module mk_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic res_key_on,
	input logic res_busy_res,
	input logic res_dropped
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid &&
			$stable({res_key_on, res_busy_res, res_dropped}))
		else $error("result changed while stalled");

	// A character is only dropped while one is being sent
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_dropped |-> res_busy_res)
		else $error("dropped while not busy");

	// Key on only during a character
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_key_on |-> res_busy_res)
		else $error("key on while idle");

	// No result right out of reset
	assert property (@(posedge clk) $rose(arst_n) |-> !res_valid)
		else $error("result valid right after reset");

endmodule

bind morse_keyer_unit mk_checker u_mk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_key_on   (res.key_on),
	.res_busy_res (res.busy_res),
	.res_dropped  (res.dropped)
);
